// ===== design/urc_pkg.sv =====
// package for the ultrasonic range controller
// word types, configuration layout and reset values; no dependencies
`timescale 1ns / 1ps

package urc_pkg;

  localparam int unsigned CounterWidthDef = 16;
  localparam int unsigned PreLowTicksDef  = 3;

  // 2/3 us per tick and 58 us per cm give 87 ticks per cm
  localparam int unsigned TicksPerCm = 87;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] ShortTimeoutRst  = 16'd15000;
  localparam logic [15:0] EchoTimeoutRst   = 16'd45000;
  localparam logic [7:0]  TrigHighRst      = 8'd15;
  localparam logic [9:0]  MinDistRst       = 10'd2;
  localparam logic [9:0]  MaxDistRst       = 10'd400;
  localparam logic [9:0]  TimeoutDistRst   = 10'd999;
  localparam logic [9:0]  ObstThresholdRst = 10'd20;

  typedef enum logic [CfgAddrW-1:0] {
    CfgShortTimeout  = 3'd0,
    CfgEchoTimeout   = 3'd1,
    CfgTrigHigh      = 3'd2,
    CfgMinDist       = 3'd3,
    CfgMaxDist       = 3'd4,
    CfgTimeoutDist   = 3'd5,
    CfgObstThreshold = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] short_wait_ticks;
    logic [15:0] echo_timeout_ticks;
    logic [7:0]  trigger_high_ticks;
    logic [9:0]  min_distance_cm;
    logic [9:0]  max_distance_cm;
    logic [9:0]  timeout_distance_cm;
    logic [9:0]  obstacle_threshold_cm;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic start_req;
    logic sensor_select;
    logic echo_front;
    logic echo_rear;
  } in_t;

  typedef struct packed {
    logic       trigger;
    logic       busy_res;
    logic       done_res;
    logic       done_sensor;
    logic [9:0] distance_cm;
    logic       timed_out;
    logic       obstacle;
  } out_t;

  // control stage result handed to the conversion stage
  typedef struct packed {
    logic trigger;
    logic busy;
    logic done;
    logic sensor;
    logic tmo;
  } ctrl_t;

endpackage

// ===== design/urc_cfg.sv =====
// configuration register file of the range controller
// depends on urc_pkg
`timescale 1ns / 1ps

module urc_cfg import urc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_wait_ticks      <= ShortTimeoutRst;
      cfg_q.echo_timeout_ticks    <= EchoTimeoutRst;
      cfg_q.trigger_high_ticks    <= TrigHighRst;
      cfg_q.min_distance_cm       <= MinDistRst;
      cfg_q.max_distance_cm       <= MaxDistRst;
      cfg_q.timeout_distance_cm   <= TimeoutDistRst;
      cfg_q.obstacle_threshold_cm <= ObstThresholdRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgShortTimeout:  cfg_q.short_wait_ticks      <= cfg_data_i;
        CfgEchoTimeout:   cfg_q.echo_timeout_ticks    <= cfg_data_i;
        CfgTrigHigh:      cfg_q.trigger_high_ticks    <= cfg_data_i[7:0];
        CfgMinDist:       cfg_q.min_distance_cm       <= cfg_data_i[9:0];
        CfgMaxDist:       cfg_q.max_distance_cm       <= cfg_data_i[9:0];
        CfgTimeoutDist:   cfg_q.timeout_distance_cm   <= cfg_data_i[9:0];
        CfgObstThreshold: cfg_q.obstacle_threshold_cm <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/urc_ctrl.sv =====
// measurement sequencer: trigger pulse, echo waits, pulse timing
// depends on urc_pkg
`timescale 1ns / 1ps

module urc_ctrl import urc_pkg::*; #(
  parameter int unsigned CounterWidth = CounterWidthDef,
  parameter int unsigned PreLowTicks  = PreLowTicksDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  in_t                     in_i,
  input  cfg_t                    cfg_i,
  output ctrl_t                   ctrl_o,
  output logic [CounterWidth-1:0] pulse_o
);

  typedef enum logic [2:0] {
    PhIdle,
    PhWaitLow,
    PhTrigLow,
    PhTrigHigh,
    PhWaitHigh,
    PhMeasure
  } phase_e;

  localparam int unsigned CmpW = (CounterWidth > 16) ? CounterWidth : 16;
  localparam logic [CounterWidth-1:0] CntMax = {CounterWidth{1'b1}};

  phase_e                  phase_q, phase_d;
  logic [CounterWidth-1:0] elapsed_q, elapsed_d;
  logic                    sensor_q, sensor_d;
  ctrl_t                   ctrl_q, ctrl_d;
  logic [CounterWidth-1:0] pulse_q, pulse_d;

  logic                    echo;
  logic                    at_short, at_echo;
  logic [CounterWidth-1:0] delay_cnt;
  logic [CounterWidth-1:0] elapsed_inc;

  assign at_short = (CmpW'(elapsed_q) >= CmpW'(cfg_i.short_wait_ticks))
                    || (elapsed_q == CntMax);
  assign at_echo  = (CmpW'(elapsed_q) >= CmpW'(cfg_i.echo_timeout_ticks))
                    || (elapsed_q == CntMax);
  assign elapsed_inc = elapsed_q + CounterWidth'(1);
  assign delay_cnt   = (elapsed_q != CntMax) ? elapsed_inc : elapsed_q;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    sensor_d  = sensor_q;
    ctrl_d    = '0;
    pulse_d   = '0;
    echo      = sensor_q ? in_i.echo_rear : in_i.echo_front;

    unique case (phase_q)
      PhIdle: begin
        if (in_i.start_req) begin
          sensor_d  = in_i.sensor_select;
          echo      = in_i.sensor_select ? in_i.echo_rear : in_i.echo_front;
          elapsed_d = '0;
          phase_d   = echo ? PhWaitLow : PhTrigLow;
        end
      end
      PhWaitLow: begin
        if (!echo) begin
          phase_d   = PhTrigLow;
          elapsed_d = '0;
        end else if (in_i.tick) begin
          if (at_short) begin
            ctrl_d.done = 1'b1;
            ctrl_d.tmo  = 1'b1;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
      end
      PhTrigLow: begin
        if (in_i.tick) begin
          if (delay_cnt >= CounterWidth'(PreLowTicks)) begin
            phase_d   = PhTrigHigh;
            elapsed_d = '0;
          end else begin
            elapsed_d = delay_cnt;
          end
        end
      end
      PhTrigHigh: begin
        if (in_i.tick) begin
          if (delay_cnt >= CounterWidth'(cfg_i.trigger_high_ticks)) begin
            phase_d   = PhWaitHigh;
            elapsed_d = '0;
          end else begin
            elapsed_d = delay_cnt;
          end
        end
      end
      PhWaitHigh: begin
        if (echo) begin
          phase_d   = PhMeasure;
          elapsed_d = '0;
        end else if (in_i.tick) begin
          if (at_short) begin
            ctrl_d.done = 1'b1;
            ctrl_d.tmo  = 1'b1;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
      end
      PhMeasure: begin
        if (!echo) begin
          ctrl_d.done = 1'b1;
          pulse_d     = elapsed_q;
        end else if (in_i.tick) begin
          if (at_echo) begin
            ctrl_d.done = 1'b1;
            ctrl_d.tmo  = 1'b1;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase

    if (ctrl_d.done) begin
      phase_d   = PhIdle;
      elapsed_d = '0;
    end

    ctrl_d.sensor  = ctrl_d.done & sensor_d;
    ctrl_d.trigger = (phase_d == PhTrigHigh);
    ctrl_d.busy    = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      elapsed_q <= '0;
      sensor_q  <= 1'b0;
      ctrl_q    <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      sensor_q  <= sensor_d;
      ctrl_q    <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      pulse_q <= pulse_d;
    end
  end

  assign ctrl_o  = ctrl_q;
  assign pulse_o = pulse_q;

endmodule

// ===== design/urc_conv.sv =====
// pulse width to distance conversion and range checks
// depends on urc_pkg; divide by 87 done as a reciprocal multiply
`timescale 1ns / 1ps

module urc_conv import urc_pkg::*; #(
  parameter int unsigned CounterWidth = CounterWidthDef
) (
  input  ctrl_t                   ctrl_i,
  input  logic [CounterWidth-1:0] pulse_i,
  input  cfg_t                    cfg_i,
  output out_t                    res_o
);

  // exact floor(p / 87) for every p below 2**CounterWidth
  localparam int unsigned Shift = CounterWidth + 7;
  localparam longint unsigned RecipL =
    ((longint'(1) << Shift) + longint'(TicksPerCm) - 1) / longint'(TicksPerCm);
  localparam logic [CounterWidth:0] Recip = RecipL[CounterWidth:0];
  localparam int unsigned ProdW = 2 * CounterWidth + 1;
  localparam int unsigned QuotW = CounterWidth - 6;
  localparam int unsigned DistW = (QuotW > 10) ? QuotW : 10;

  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;
  logic [DistW-1:0] clamped;
  logic             short_pulse;
  logic             tmo;
  logic [9:0]       range_cm;

  assign prod        = ProdW'(pulse_i) * ProdW'(Recip);
  assign quot        = prod[Shift +: QuotW];
  assign short_pulse = (pulse_i < CounterWidth'(2));
  assign clamped     = (DistW'(quot) < DistW'(cfg_i.min_distance_cm)) ?
                       DistW'(cfg_i.min_distance_cm) : DistW'(quot);

  always_comb begin
    tmo      = ctrl_i.tmo || short_pulse || (clamped > DistW'(cfg_i.max_distance_cm));
    range_cm = tmo ? cfg_i.timeout_distance_cm : clamped[9:0];
    if (!ctrl_i.done) begin
      tmo      = 1'b0;
      range_cm = '0;
    end
    res_o.trigger     = ctrl_i.trigger;
    res_o.busy_res    = ctrl_i.busy;
    res_o.done_res    = ctrl_i.done;
    res_o.done_sensor = ctrl_i.sensor;
    res_o.distance_cm = range_cm;
    res_o.timed_out   = tmo;
    res_o.obstacle    = ctrl_i.done && (range_cm < cfg_i.timeout_distance_cm)
                        && (range_cm <= cfg_i.obstacle_threshold_cm);
  end

endmodule

// ===== design/ultrasonic_range_controller.sv =====
// ultrasonic range controller top level: one result word per input word
// each input word passes the input, control stage and output registers in turn
// throughput: one word per cycle; all stages stall together while the output is held
// config writes take effect on the next cycle; the register file resets to its defaults
// reset clears the sequencer to idle and empties every stage
// depends on urc_pkg, urc_cfg, urc_ctrl, urc_conv
`timescale 1ns / 1ps

module ultrasonic_range_controller import urc_pkg::*; #(
  parameter int unsigned CounterWidth = CounterWidthDef,
  parameter int unsigned PreLowTicks  = PreLowTicksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic                    adv;
  logic                    s1_valid_q, s2_valid_q, out_valid_q;
  in_t                     in_q;
  out_t                    out_q;
  cfg_t                    cfg;
  ctrl_t                   ctrl;
  logic [CounterWidth-1:0] pulse;
  out_t                    res;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  urc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  urc_ctrl #(
    .CounterWidth (CounterWidth),
    .PreLowTicks  (PreLowTicks)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv && s1_valid_q),
    .in_i    (in_q),
    .cfg_i   (cfg),
    .ctrl_o  (ctrl),
    .pulse_o (pulse)
  );

  urc_conv #(
    .CounterWidth (CounterWidth)
  ) u_conv (
    .ctrl_i  (ctrl),
    .pulse_i (pulse),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (adv && s2_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a completed measurement leaves the sequencer idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done word reports busy");

  // trigger is only driven during a measurement
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trigger |-> out_data_o.busy_res)
    else $error("trigger high while idle");

  // result flags only on a done word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.timed_out || out_data_o.obstacle) |-> out_data_o.done_res)
    else $error("result flag without done");

  // the pipeline only stalls on a held output word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule
